@@ hdl/dqkr_pkg.sv @@
// Shared types and codes for the keyed-removal deque.
package dqkr_pkg;

  localparam int KEY_W  = 32;
  localparam int WORD_W = 32;

  localparam logic [1:0] OP_PUSH_FRONT = 2'd0;
  localparam logic [1:0] OP_PUSH_BACK  = 2'd1;
  localparam logic [1:0] OP_POP_BACK   = 2'd2;
  localparam logic [1:0] OP_DELETE     = 2'd3;

  localparam logic [1:0] ST_DONE  = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_POP_CAP,
    S_SCAN,
    S_SHIFT,
    S_DONE
  } state_t;

  typedef struct packed {
    logic [1:0]        status;
    logic [KEY_W-1:0]  key;
    logic [WORD_W-1:0] data;
  } res_t;

endpackage

@@ hdl/dqkr_if.sv @@
// Request and result channel interfaces for the keyed-removal deque.
interface dqkr_in_if;
  logic                       valid;
  logic                       ready;
  logic [1:0]                 op;
  logic [dqkr_pkg::KEY_W-1:0]  key;
  logic [dqkr_pkg::WORD_W-1:0] data;
  modport source (output valid, op, key, data, input ready);
  modport sink (input valid, op, key, data, output ready);
endinterface

interface dqkr_out_if;
  logic                       valid;
  logic                       ready;
  logic [1:0]                 status;
  logic [dqkr_pkg::KEY_W-1:0]  out_key;
  logic [dqkr_pkg::WORD_W-1:0] out_data;
  modport source (output valid, status, out_key, out_data, input ready);
  modport sink (input valid, status, out_key, out_data, output ready);
endinterface

@@ hdl/dqkr_store.sv @@
// Record memory: one write port and one registered read port.
module dqkr_store #(
  parameter int DEPTH = 16,
  parameter int REC_W = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [REC_W-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [REC_W-1:0]         rdata
);

  logic [REC_W-1:0] mem [DEPTH];
  logic [REC_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

@@ hdl/dqkr_ctrl.sv @@
// Request sequencer: shared slot adder and key compare, scan and close-up passes.
module dqkr_ctrl #(
  parameter int DEPTH      = 16,
  parameter int DATA_WIDTH = 32
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        req_valid,
  output logic                        req_ready,
  input  logic [1:0]                  req_op,
  input  logic [dqkr_pkg::KEY_W-1:0]  req_key,
  input  logic [dqkr_pkg::WORD_W-1:0] req_data,
  output logic                        res_valid,
  input  logic                        res_take,
  output dqkr_pkg::res_t              res
);

  localparam int AW    = $clog2(DEPTH);
  localparam int CW    = $clog2(DEPTH + 1);
  localparam int REC_W = dqkr_pkg::KEY_W + DATA_WIDTH;

  dqkr_pkg::state_t state_r, state_nxt;
  logic [1:0]                  op_r;
  logic [dqkr_pkg::KEY_W-1:0]  key_r;
  logic [dqkr_pkg::WORD_W-1:0] data_r;
  logic [AW-1:0] front_r, front_nxt;
  logic [CW-1:0] fill_r, fill_nxt;
  logic [CW-1:0] idx_r, idx_nxt;
  logic          cmp_v_r, cmp_v_nxt;
  logic          shv_r, shv_nxt;
  logic [AW-1:0] rd_slot_r, rd_slot_nxt;
  logic [AW-1:0] wr_slot_r, wr_slot_nxt;
  dqkr_pkg::res_t res_r, res_nxt;

  // memory port
  logic             we, re;
  logic [AW-1:0]    waddr, raddr;
  logic [REC_W-1:0] wdata, rdata;

  // shared slot unit
  logic [AW-1:0] slot_pos, slot, front_dec;
  logic [AW:0]   slot_sum;
  logic          full, empty;
  logic [CW-1:0] fill_m1;
  logic [63:0]   din_ext, rpay_ext;
  logic [DATA_WIDTH-1:0]      wpay;
  logic [dqkr_pkg::KEY_W-1:0] rkey;

  assign slot_sum = {1'b0, front_r} + {1'b0, slot_pos};
  assign slot = (slot_sum >= (AW+1)'(DEPTH)) ? AW'(slot_sum - (AW+1)'(DEPTH))
                                              : slot_sum[AW-1:0];
  assign front_dec = (front_r == '0) ? AW'(DEPTH - 1) : front_r - AW'(1);
  assign full    = (fill_r == CW'(DEPTH));
  assign empty   = (fill_r == '0);
  assign fill_m1 = fill_r - CW'(1);

  assign din_ext  = 64'(data_r);
  assign wpay     = din_ext[DATA_WIDTH-1:0];
  assign rkey     = rdata[DATA_WIDTH +: dqkr_pkg::KEY_W];
  assign rpay_ext = 64'(rdata[DATA_WIDTH-1:0]);

  dqkr_store #(.DEPTH(DEPTH), .REC_W(REC_W)) u_store (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .re    (re),
    .raddr (raddr),
    .rdata (rdata)
  );

  always_comb begin
    state_nxt   = state_r;
    front_nxt   = front_r;
    fill_nxt    = fill_r;
    idx_nxt     = idx_r;
    cmp_v_nxt   = cmp_v_r;
    shv_nxt     = shv_r;
    rd_slot_nxt = rd_slot_r;
    wr_slot_nxt = wr_slot_r;
    res_nxt     = res_r;
    we          = 1'b0;
    re          = 1'b0;
    waddr       = slot;
    raddr       = slot;
    wdata       = {key_r, wpay};
    req_ready   = 1'b0;
    res_valid   = 1'b0;

    case (state_r)
      dqkr_pkg::S_EXEC: slot_pos = (op_r == dqkr_pkg::OP_POP_BACK) ? fill_m1[AW-1:0]
                                                                    : fill_r[AW-1:0];
      default:          slot_pos = idx_r[AW-1:0];
    endcase

    case (state_r)
      dqkr_pkg::S_IDLE: begin
        req_ready = 1'b1;
        if (req_valid) begin
          state_nxt = dqkr_pkg::S_EXEC;
        end
      end
      dqkr_pkg::S_EXEC: begin
        res_nxt   = '{status: dqkr_pkg::ST_DONE, key: '0, data: '0};
        state_nxt = dqkr_pkg::S_DONE;
        case (op_r)
          dqkr_pkg::OP_PUSH_FRONT: begin
            if (full) begin
              res_nxt.status = dqkr_pkg::ST_FULL;
            end else begin
              we        = 1'b1;
              waddr     = front_dec;
              front_nxt = front_dec;
              fill_nxt  = fill_r + CW'(1);
            end
          end
          dqkr_pkg::OP_PUSH_BACK: begin
            if (full) begin
              res_nxt.status = dqkr_pkg::ST_FULL;
            end else begin
              we       = 1'b1;
              fill_nxt = fill_r + CW'(1);
            end
          end
          dqkr_pkg::OP_POP_BACK: begin
            if (empty) begin
              res_nxt.status = dqkr_pkg::ST_EMPTY;
            end else begin
              re        = 1'b1;
              fill_nxt  = fill_m1;
              state_nxt = dqkr_pkg::S_POP_CAP;
            end
          end
          default: begin
            if (empty) begin
              res_nxt.status = dqkr_pkg::ST_EMPTY;
            end else begin
              idx_nxt   = '0;
              cmp_v_nxt = 1'b0;
              state_nxt = dqkr_pkg::S_SCAN;
            end
          end
        endcase
      end
      dqkr_pkg::S_POP_CAP: begin
        res_nxt.key  = rkey;
        res_nxt.data = rpay_ext[dqkr_pkg::WORD_W-1:0];
        state_nxt    = dqkr_pkg::S_DONE;
      end
      dqkr_pkg::S_SCAN: begin
        if (cmp_v_r && (rkey == key_r)) begin
          // hit on the entry read last cycle; idx_r already points past it
          res_nxt.key  = rkey;
          res_nxt.data = rpay_ext[dqkr_pkg::WORD_W-1:0];
          wr_slot_nxt  = rd_slot_r;
          shv_nxt      = 1'b0;
          state_nxt    = dqkr_pkg::S_SHIFT;
        end else if (idx_r < fill_r) begin
          re          = 1'b1;
          rd_slot_nxt = slot;
          idx_nxt     = idx_r + CW'(1);
          cmp_v_nxt   = 1'b1;
        end else begin
          res_nxt.status = dqkr_pkg::ST_EMPTY;
          state_nxt      = dqkr_pkg::S_DONE;
        end
      end
      dqkr_pkg::S_SHIFT: begin
        // move each later record one slot toward the front
        if (shv_r) begin
          we          = 1'b1;
          waddr       = wr_slot_r;
          wdata       = rdata;
          wr_slot_nxt = rd_slot_r;
        end
        if (idx_r < fill_r) begin
          re          = 1'b1;
          rd_slot_nxt = slot;
          idx_nxt     = idx_r + CW'(1);
          shv_nxt     = 1'b1;
        end else begin
          shv_nxt = 1'b0;
          if (!shv_r) begin
            fill_nxt  = fill_m1;
            state_nxt = dqkr_pkg::S_DONE;
          end
        end
      end
      dqkr_pkg::S_DONE: begin
        res_valid = 1'b1;
        if (res_take) begin
          state_nxt = dqkr_pkg::S_IDLE;
        end
      end
      default: state_nxt = dqkr_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= dqkr_pkg::S_IDLE;
      front_r <= '0;
      fill_r  <= '0;
      cmp_v_r <= 1'b0;
      shv_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      front_r <= front_nxt;
      fill_r  <= fill_nxt;
      cmp_v_r <= cmp_v_nxt;
      shv_r   <= shv_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (req_ready && req_valid) begin
      op_r   <= req_op;
      key_r  <= req_key;
      data_r <= req_data;
    end
    idx_r     <= idx_nxt;
    rd_slot_r <= rd_slot_nxt;
    wr_slot_r <= wr_slot_nxt;
    res_r     <= res_nxt;
  end

  assign res = res_r;

endmodule

@@ hdl/deque_with_keyed_removal_top.sv @@
// Top level of the bounded deque of keyed records with delete by key.
//
// in_ch carries one request beat (op, key, data); out_ch returns exactly one
// result beat (status, out_key, out_data) per request, in request order.
// Requests are taken one at a time: in_ch.ready is high only while the
// sequencer is idle.
// A push or a refused request runs the execute state and then the done state;
// a pop adds a capture state for the record read. A delete scans from the
// front one record a cycle through the single memory read port and compares
// in the following cycle, then closes the gap one record a cycle.
// After each result the sequencer returns to idle before it takes the next
// request.
// The result sits in an output register; a new request is accepted while it
// waits. If out_ch stalls, the next result holds in the sequencer and no
// further request is taken until the register frees.
// Reset empties the store at once (front and fill count cleared); no clearing
// pass is run and record memory contents are left as they are.
module deque_with_keyed_removal_top #(
  parameter int DEPTH      = 16,
  parameter int DATA_WIDTH = 32
) (
  input logic             clk,
  input logic             rst_n,
  dqkr_in_if.sink         in_ch,
  dqkr_out_if.source      out_ch
);

  logic           res_valid, res_take;
  dqkr_pkg::res_t res;
  logic           out_valid_r;
  dqkr_pkg::res_t out_r;

  dqkr_ctrl #(.DEPTH(DEPTH), .DATA_WIDTH(DATA_WIDTH)) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (in_ch.valid),
    .req_ready (in_ch.ready),
    .req_op    (in_ch.op),
    .req_key   (in_ch.key),
    .req_data  (in_ch.data),
    .res_valid (res_valid),
    .res_take  (res_take),
    .res       (res)
  );

  // load the output register when it is empty or being drained this cycle
  assign res_take = !out_valid_r || out_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_valid && res_take) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_take) begin
      out_r <= res;
    end
  end

  assign out_ch.valid    = out_valid_r;
  assign out_ch.status   = out_r.status;
  assign out_ch.out_key  = out_r.key;
  assign out_ch.out_data = out_r.data;

endmodule
